[hdl/hde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hde_pkg
// Shared widths, limits, register indexes and types of the heat diffusion
// stencil core.
// ----------------------------------------------------------------------------
package hde_pkg;

	localparam int LINE_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);

	localparam int TEMP_W  = 32;
	localparam int COEF_W  = 16;
	localparam int ROW_W   = 16;
	localparam int COL_W   = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [ROW_W-1:0] ROWS_MAX = ROW_W'(65533);
	localparam logic [COL_W-1:0] COLS_MAX = COL_W'(LINE_DEPTH - 2);

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [COEF_W-1:0]        coef_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [COL_W-1:0]         col_t;
	typedef logic [ADDR_W-1:0]        addr_t;

	typedef enum logic [1:0] {
		REG_COEF_X    = 2'd0,
		REG_COEF_Y    = 2'd1,
		REG_GRID_ROWS = 2'd2,
		REG_GRID_COLS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		coef_t coef_x;
		coef_t coef_y;
		row_t  grid_rows;
		col_t  grid_cols;
	} cfg_t;

endpackage

[hdl/hde_sample_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hde_sample_if
// Valid/ready channel carrying one grid point temperature per beat.
// ----------------------------------------------------------------------------
interface hde_sample_if;
	logic           valid;
	logic           ready;
	hde_pkg::temp_t temperature;

	modport source (output valid, output temperature, input ready);
	modport sink   (input valid, input temperature, output ready);
endinterface

[hdl/hde_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hde_result_if
// Valid/ready channel carrying one updated interior point per beat.
// ----------------------------------------------------------------------------
interface hde_result_if;
	logic           valid;
	logic           ready;
	hde_pkg::temp_t new_temperature;
	hde_pkg::row_t  out_row;
	hde_pkg::col_t  out_col;
	logic           last_point;

	modport source (output valid, output new_temperature, output out_row,
		output out_col, output last_point, input ready);
	modport sink   (input valid, input new_temperature, input out_row,
		input out_col, input last_point, output ready);
endinterface

[hdl/heat_diffusion_explicit_stencil_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_explicit_stencil_core
// Streaming five-point FTCS heat step with two line memories.
//
//  channel   dir  width            contents
//  samples   in   32               temperature, row-major, boundary included
//  results   out  32+16+10+1       new_temperature, out_row, out_col, last_point
//  apb       in   4 addr, 32 data  coef_x, coef_y, grid_rows, grid_cols
//
// One grid point is accepted per cycle unless the pipeline stalls. The lower
// neighbour's beat passes memory read, difference, multiply, then round and
// saturate into the output register. Reset clears counters, the west register
// and all stage valid bits; the line memories need no clearing pass. A stalled
// output holds its register while the stages behind it keep filling bubbles.
// ----------------------------------------------------------------------------
module heat_diffusion_explicit_stencil_core (
	input  logic                          clk,
	input  logic                          arst_n,
	hde_sample_if.sink                    samples,
	hde_result_if.source                  results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hde_pkg::PADDR_W-1:0]   paddr,
	input  logic [hde_pkg::PDATA_W-1:0]   pwdata,
	output logic [hde_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import hde_pkg::*;

	cfg_t cfg;

	hde_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Line memories: mem_a holds the row above the incoming one, mem_b two above.
	temp_t mem_a [LINE_DEPTH];
	temp_t mem_b [LINE_DEPTH];

	row_t  row_q;
	col_t  col_q;
	temp_t west_q;

	row_t  rows_eff, rows_p1;
	col_t  cols_eff, cols_p1;
	logic  emit_s0;
	logic  accept;
	addr_t ca, ea;

	// Stage 1: memory read data.
	logic  v_s1, emit_s1, last_s1;
	temp_t centre_s1, east_s1, north_s1, south_s1;
	addr_t addr_s1;
	row_t  row_s1;
	col_t  col_s1;

	// Stage 2: second differences.
	logic               v_s2, last_s2;
	temp_t              t_s2;
	logic signed [33:0] dr_s2, dc_s2;
	row_t               row_s2;
	col_t               col_s2;

	// Stage 3: products.
	logic               v_s3, last_s3;
	temp_t              t_s3;
	logic signed [50:0] px_s3, py_s3;
	row_t               row_s3;
	col_t               col_s3;

	// Output register.
	logic  out_v_q, out_last_q;
	temp_t out_temp_q;
	row_t  out_row_q;
	col_t  out_col_q;

	logic go_out, go_s3, go_s2, go_s1, fire_s1;

	logic [33:0]        dr_c, dc_c;
	logic signed [51:0] acc;
	logic signed [36:0] sum;
	temp_t              sat;

	always_comb begin
		if (cfg.grid_rows == '0)          rows_eff = ROW_W'(1);
		else if (cfg.grid_rows > ROWS_MAX) rows_eff = ROWS_MAX;
		else                               rows_eff = cfg.grid_rows;
		if (cfg.grid_cols == '0)          cols_eff = COL_W'(1);
		else if (cfg.grid_cols > COLS_MAX) cols_eff = COLS_MAX;
		else                               cols_eff = cfg.grid_cols;
	end

	assign rows_p1 = rows_eff + ROW_W'(1);
	assign cols_p1 = cols_eff + COL_W'(1);
	assign emit_s0 = (row_q >= ROW_W'(2)) && (row_q <= rows_p1) &&
		(col_q >= COL_W'(1)) && (col_q <= cols_eff);

	assign ca = ADDR_W'(col_q);
	assign ea = ADDR_W'(col_q + COL_W'(1));

	// Elastic handshake: each stage loads when empty or when it drains.
	assign go_out  = !out_v_q || results.ready;
	assign go_s3   = !v_s3 || go_out;
	assign go_s2   = !v_s2 || go_s3;
	assign go_s1   = !v_s1 || !emit_s1 || go_s2;
	assign fire_s1 = v_s1 && (!emit_s1 || go_s2);

	assign samples.ready = go_s1;
	assign accept        = samples.valid && samples.ready;

	// Counters advance on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q >= cols_p1) begin
				col_q <= '0;
				row_q <= (row_q >= rows_p1) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Two consecutive beats never touch the same column, so the deferred
	// write to mem_b cannot collide with the next read.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_a[ca] <= samples.temperature;
			centre_s1 <= mem_a[ca];
			east_s1   <= mem_a[ea];
			north_s1  <= mem_b[ca];
			south_s1  <= samples.temperature;
			addr_s1   <= ca;
			row_s1    <= row_q - ROW_W'(1);
			col_s1    <= col_q;
			last_s1   <= ((row_q - ROW_W'(1)) == rows_eff) && (col_q == cols_eff);
		end
		if (fire_s1) begin
			mem_b[addr_s1] <= centre_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			west_q  <= '0;
		end else begin
			if (go_s1) begin
				v_s1    <= accept;
				emit_s1 <= accept && emit_s0;
			end
			if (fire_s1) begin
				west_q <= centre_s1;
			end
		end
	end

	assign dr_c = {{2{north_s1[31]}}, north_s1} + {{2{south_s1[31]}}, south_s1}
		- {centre_s1[31], centre_s1, 1'b0};
	assign dc_c = {{2{east_s1[31]}}, east_s1} + {{2{west_q[31]}}, west_q}
		- {centre_s1[31], centre_s1, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (go_s2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			t_s2    <= centre_s1;
			dr_s2   <= $signed(dr_c);
			dc_s2   <= $signed(dc_c);
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (go_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3) begin
			t_s3    <= t_s2;
			px_s3   <= $signed({1'b0, cfg.coef_x}) * dr_s2;
			py_s3   <= $signed({1'b0, cfg.coef_y}) * dc_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
		end
	end

	// Round to nearest with ties upward, then saturate the updated value.
	always_comb begin
		acc = {px_s3[50], px_s3} + {py_s3[50], py_s3} + 52'sd32768;
		sum = {{5{t_s3[31]}}, t_s3} + {acc[51], acc[51:16]};
		if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
			sat = sum[31:0];
		end else if (sum[36]) begin
			sat = {1'b1, {(TEMP_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(TEMP_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (go_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) begin
			out_temp_q <= sat;
			out_row_q  <= row_s3;
			out_col_q  <= col_s3;
			out_last_q <= last_s3;
		end
	end

	assign results.valid           = out_v_q;
	assign results.new_temperature = out_temp_q;
	assign results.out_row         = out_row_q;
	assign results.out_col         = out_col_q;
	assign results.last_point      = out_last_q;
endmodule

[hdl/hde_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hde_apb_regs
// APB register file holding the two diffusion coefficients and grid sizes.
// ----------------------------------------------------------------------------
module hde_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hde_pkg::PADDR_W-1:0]   paddr,
	input  logic [hde_pkg::PDATA_W-1:0]   pwdata,
	output logic [hde_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output hde_pkg::cfg_t                 cfg
);
	import hde_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_x    <= '0;
			cfg_q.coef_y    <= '0;
			cfg_q.grid_rows <= ROW_W'(1);
			cfg_q.grid_cols <= COL_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_COEF_X:    cfg_q.coef_x    <= pwdata[COEF_W-1:0];
				REG_COEF_Y:    cfg_q.coef_y    <= pwdata[COEF_W-1:0];
				REG_GRID_ROWS: cfg_q.grid_rows <= pwdata[ROW_W-1:0];
				REG_GRID_COLS: cfg_q.grid_cols <= pwdata[COL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COEF_X:    prdata = PDATA_W'(cfg_q.coef_x);
			REG_COEF_Y:    prdata = PDATA_W'(cfg_q.coef_y);
			REG_GRID_ROWS: prdata = PDATA_W'(cfg_q.grid_rows);
			REG_GRID_COLS: prdata = PDATA_W'(cfg_q.grid_cols);
			default:       prdata = '0;
		endcase
	end
endmodule

[dv/heat_diffusion_explicit_stencil_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_diffusion_explicit_stencil_core_test
// Self-checking bench for the streaming five-point heat stencil. Grids are
// streamed point by point over the sample channel while a bit-accurate
// predictor tracks the line stores and counters and queues the updated
// interior points. Each result beat is compared field by field with the
// oldest queued point. Registers are programmed and read back over APB
// between grids and within them, with random idling on both channels.
// ----------------------------------------------------------------------------
module heat_diffusion_explicit_stencil_core_test;
	import hde_pkg::*;

	localparam int     CLK_PERIOD     = 10;
	localparam int     RESET_CYCLES   = 4;
	localparam int     SETTLE_CYCLES  = 12;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     RANDOM_POINTS  = 1000;
	localparam int     TALL_POINTS    = 60;
	localparam int     MAX_REPORTS    = 40;
	localparam longint SAT_HI         = 64'sd2147483647;
	localparam longint SAT_LO         = -64'sd2147483648;
	localparam temp_t  TEMP_MAX       = 32'sh7fff_ffff;
	localparam temp_t  TEMP_MIN       = 32'sh8000_0000;

	typedef enum int {
		VAL_FULL,
		VAL_NEAR,
		VAL_EDGE
	} value_mode_t;

	typedef struct {
		temp_t temp;
		row_t  row;
		col_t  col;
		logic  last;
	} heat_point_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	hde_sample_if samples_ch ();
	hde_result_if results_ch ();

	heat_diffusion_explicit_stencil_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: mirrored configuration, line stores and stream position.
	coef_t       cfg_coef_x;
	coef_t       cfg_coef_y;
	row_t        cfg_rows;
	col_t        cfg_cols;
	temp_t       upper_line [LINE_DEPTH];
	temp_t       upper2_line [LINE_DEPTH];
	temp_t       west_val;
	int unsigned pos_row;
	int unsigned pos_col;
	heat_point_t pending_points [$];

	int   error_count;
	int   points_sent;
	int   results_checked;
	int   grids_done;
	int   quiet_cycles;
	logic src_idle_en;
	logic sink_idle_en;
	logic hold_req;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void report_mismatch(string what, logic [31:0] expected_val,
		logic [31:0] actual_val);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what,
				expected_val, actual_val);
		end
	endfunction

	function automatic temp_t ftcs_update(temp_t t, temp_t n, temp_t s, temp_t e, temp_t w);
		longint d_row;
		longint d_col;
		longint acc;
		longint sum;
		d_row = longint'(n) + longint'(s) - 2 * longint'(t);
		d_col = longint'(e) + longint'(w) - 2 * longint'(t);
		// Round to nearest with ties up: add half an LSB, then floor.
		acc = longint'(cfg_coef_x) * d_row + longint'(cfg_coef_y) * d_col + 64'sd32768;
		sum = longint'(t) + (acc >>> 16);
		if (sum > SAT_HI) sum = SAT_HI;
		if (sum < SAT_LO) sum = SAT_LO;
		return temp_t'(sum[31:0]);
	endfunction

	function automatic void advance_stream(temp_t t_in);
		int unsigned rows;
		int unsigned cols;
		int unsigned r;
		int unsigned c;
		temp_t       centre;
		heat_point_t pt;
		rows = cfg_rows;
		cols = cfg_cols;
		if (rows < 1) rows = 1;
		if (rows > ROWS_MAX) rows = ROWS_MAX;
		if (cols < 1) cols = 1;
		if (cols > COLS_MAX) cols = COLS_MAX;
		r = pos_row;
		c = pos_col;
		if (c < LINE_DEPTH) begin
			centre = upper_line[c];
			// The incoming point is the south neighbour of the centre one row up.
			if (r >= 2 && r <= rows + 1 && c >= 1 && c <= cols && c + 1 < LINE_DEPTH) begin
				pt.temp = ftcs_update(centre, upper2_line[c], t_in, upper_line[c + 1], west_val);
				pt.row  = row_t'(r - 1);
				pt.col  = col_t'(c);
				pt.last = (r - 1 == rows && c == cols);
				pending_points.push_back(pt);
			end
			west_val       = centre;
			upper2_line[c] = centre;
			upper_line[c]  = t_in;
		end
		if (c >= cols + 1) begin
			pos_col = 0;
			if (r >= rows + 1) begin
				pos_row = 0;
				grids_done++;
			end else begin
				pos_row = r + 1;
			end
		end else begin
			pos_col = c + 1;
		end
	endfunction

	function automatic temp_t pick_temp(value_mode_t mode);
		temp_t v;
		case (mode)
			VAL_FULL: v = temp_t'($urandom);
			VAL_NEAR: v = 32'sh0064_0000 + int'($urandom_range(0, 4194303)) - 2097152;
			default: begin
				case ($urandom_range(0, 5))
					0: v = TEMP_MAX;
					1: v = TEMP_MIN;
					2: v = '0;
					3: v = -1;
					4: v = 1;
					default: v = temp_t'($urandom);
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic send_point(temp_t value);
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			samples_ch.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		samples_ch.valid       = 1'b1;
		samples_ch.temperature = value;
		@(posedge clk);
		while (!samples_ch.ready) @(posedge clk);
		advance_stream(value);
		points_sent++;
	endtask

	// Streams points until the position counters wrap, which completes the grid
	// currently in progress (or one whole grid when starting at its origin).
	task automatic send_grid(value_mode_t mode);
		do begin
			send_point(pick_temp(mode));
		end while (!(pos_row == 0 && pos_col == 0));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		samples_ch.valid = 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_reg(reg_idx_t idx, output logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = PADDR_W'(4 * int'(idx));
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic program_reg(reg_idx_t idx, logic [31:0] value);
		logic [31:0] stored;
		logic [31:0] readback;
		wait_drained();
		case (idx)
			REG_COEF_X:    stored = value & 32'h0000_ffff;
			REG_COEF_Y:    stored = value & 32'h0000_ffff;
			REG_GRID_ROWS: stored = value & 32'h0000_ffff;
			default:       stored = value & 32'h0000_03ff;
		endcase
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(4 * int'(idx));
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_COEF_X:    cfg_coef_x = coef_t'(stored);
			REG_COEF_Y:    cfg_coef_y = coef_t'(stored);
			REG_GRID_ROWS: cfg_rows   = row_t'(stored);
			default:       cfg_cols   = col_t'(stored);
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		read_reg(idx, readback);
		if (readback !== stored) report_mismatch("register readback", stored, readback);
	endtask

	task automatic test_reset_defaults();
		logic [31:0] data;
		read_reg(REG_COEF_X, data);
		if (data !== 32'd0) report_mismatch("coef_x reset", 32'd0, data);
		read_reg(REG_COEF_Y, data);
		if (data !== 32'd0) report_mismatch("coef_y reset", 32'd0, data);
		read_reg(REG_GRID_ROWS, data);
		if (data !== 32'd1) report_mismatch("grid_rows reset", 32'd1, data);
		read_reg(REG_GRID_COLS, data);
		if (data !== 32'd1) report_mismatch("grid_cols reset", 32'd1, data);
		// Zero coefficients pass the centre value through unchanged.
		send_grid(VAL_FULL);
	endtask

	task automatic test_saturation();
		temp_t pts [12];
		program_reg(REG_COEF_X, 32'd65535);
		program_reg(REG_COEF_Y, 32'd65535);
		program_reg(REG_GRID_ROWS, 32'd1);
		program_reg(REG_GRID_COLS, 32'd2);
		// The left interior point saturates high, the right one low.
		pts = '{'0, TEMP_MAX, TEMP_MIN, '0,
			TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN,
			'0, TEMP_MAX, TEMP_MIN, '0};
		foreach (pts[i]) send_point(pts[i]);
	endtask

	task automatic test_rounding_ties();
		temp_t pts [12];
		program_reg(REG_COEF_X, 32'd32768);
		program_reg(REG_COEF_Y, 32'd0);
		// A correction of exactly +1/2 LSB rounds up, and -1/2 LSB rounds to zero.
		pts = '{'0, 32'sd1, -32'sd1, '0,
			'0, '0, '0, '0,
			'0, '0, '0, '0};
		foreach (pts[i]) send_point(pts[i]);
	endtask

	task automatic test_size_limits();
		program_reg(REG_COEF_X, pick_coef());
		program_reg(REG_COEF_Y, pick_coef());
		// Zero sizes behave as a single interior point.
		program_reg(REG_GRID_ROWS, 32'd0);
		program_reg(REG_GRID_COLS, 32'd0);
		send_grid(VAL_FULL);
		// An oversized column count is stored as written and clamped only in use.
		program_reg(REG_GRID_COLS, 32'd1023);
		program_reg(REG_GRID_COLS, 32'd1);
		// Stream the top of a very tall grid at full rate, then shrink the row
		// count so that the current row closes the grid.
		program_reg(REG_GRID_ROWS, 32'd65535);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (TALL_POINTS) send_point(pick_temp(VAL_NEAR));
		program_reg(REG_GRID_ROWS, 32'd1);
		send_grid(VAL_NEAR);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	task automatic test_midgrid_resize();
		program_reg(REG_COEF_X, pick_coef());
		program_reg(REG_COEF_Y, pick_coef());
		program_reg(REG_GRID_ROWS, 32'd3);
		program_reg(REG_GRID_COLS, 32'd4);
		repeat (15) send_point(pick_temp(VAL_FULL));
		// Grow the grid while inside it, then shrink it below the current row.
		program_reg(REG_GRID_ROWS, 32'd6);
		repeat (24) send_point(pick_temp(VAL_FULL));
		program_reg(REG_GRID_ROWS, 32'd1);
		send_grid(VAL_FULL);
	endtask

	task automatic test_output_stall();
		program_reg(REG_COEF_X, pick_coef());
		program_reg(REG_COEF_Y, pick_coef());
		program_reg(REG_GRID_ROWS, 32'd4);
		program_reg(REG_GRID_COLS, 32'd20);
		hold_req = 1'b1;
		send_grid(VAL_NEAR);
	endtask

	task automatic test_random_grids();
		int          start_count;
		int          rows;
		int          cols;
		value_mode_t mode;
		start_count = points_sent;
		while (points_sent - start_count < RANDOM_POINTS) begin
			if (points_sent - start_count > RANDOM_POINTS * 3 / 4) begin
				src_idle_en  = 1'b0;
				sink_idle_en = 1'b0;
			end
			mode = value_mode_t'($urandom_range(0, 2));
			rows = $urandom_range(1, 6);
			cols = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
			program_reg(REG_COEF_X, pick_coef());
			program_reg(REG_COEF_Y, pick_coef());
			program_reg(REG_GRID_ROWS, rows);
			program_reg(REG_GRID_COLS, cols);
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, (rows + 2) * (cols + 2) - 1)) send_point(pick_temp(mode));
				program_reg(REG_GRID_ROWS, $urandom_range(1, 6));
			end
			send_grid(mode);
		end
	endtask

	// Result sink: random stall bursts, plus one long hold-off on request.
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				results_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				results_ch.ready = 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				results_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		heat_point_t exp_pt;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_points.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("%0t: unexpected result beat, expected none, actual %h row %0d col %0d",
						$time, results_ch.new_temperature, results_ch.out_row, results_ch.out_col);
				end
			end else begin
				exp_pt = pending_points.pop_front();
				if (results_ch.new_temperature !== exp_pt.temp)
					report_mismatch("new_temperature", exp_pt.temp, results_ch.new_temperature);
				if (results_ch.out_row !== exp_pt.row)
					report_mismatch("out_row", exp_pt.row, results_ch.out_row);
				if (results_ch.out_col !== exp_pt.col)
					report_mismatch("out_col", exp_pt.col, results_ch.out_col);
				if (results_ch.last_point !== exp_pt.last)
					report_mismatch("last_point", exp_pt.last, results_ch.last_point);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (samples_ch.valid && samples_ch.ready) ||
			(results_ch.valid && results_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("heat_diffusion_explicit_stencil_core_test failed");
			$finish;
		end
	end

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		samples_ch.valid       = 1'b0;
		samples_ch.temperature = '0;
		cfg_coef_x             = '0;
		cfg_coef_y             = '0;
		cfg_rows               = row_t'(1);
		cfg_cols               = col_t'(1);
		west_val               = '0;
		pos_row                = 0;
		pos_col                = 0;
		error_count            = 0;
		points_sent            = 0;
		results_checked        = 0;
		grids_done             = 0;
		quiet_cycles           = 0;
		src_idle_en            = 1'b1;
		sink_idle_en           = 1'b1;
		hold_req               = 1'b0;
		foreach (upper_line[i]) begin
			upper_line[i]  = '0;
			upper2_line[i] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_saturation();
		test_rounding_ties();
		test_size_limits();
		test_midgrid_resize();
		test_output_stall();
		test_random_grids();
		wait_drained();

		if (pending_points.size() != 0) begin
			error_count++;
			$display("%0t: %0d updated points never arrived", $time, pending_points.size());
		end
		$display("Streamed %0d grid points in %0d grids and checked %0d updated points.",
			points_sent, grids_done, results_checked);
		$display("Covered saturation, rounding ties, size clamps, mid-grid resizing and a long stall.");
		if (error_count == 0) begin
			$display("heat_diffusion_explicit_stencil_core_test passed");
		end else begin
			$display("heat_diffusion_explicit_stencil_core_test failed");
		end
		$finish;
	end

endmodule
